/* hdl/prefix_code_stream_decoder_top_defines.svh */
// Assertion macros for the prefix code stream decoder.
`ifndef PREFIX_CODE_STREAM_DECODER_TOP_DEFINES_SVH
`define PREFIX_CODE_STREAM_DECODER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low
`define PCSD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcsd: implication check failed");
// Next-cycle implication, sampled on clk, off while rst_n is low
`define PCSD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcsd: next-cycle check failed");
`else
`define PCSD_ASSERT_IMP(lbl, ante, cons)
`define PCSD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* hdl/pcsd_pkg.sv */
// Shared types and constants of the prefix code stream decoder.
package pcsd_pkg;

  // Field widths of the transfer payloads
  localparam int unsigned CFG_W      = 7;
  localparam int unsigned IDXF_W     = 6;
  localparam int unsigned CODE_W     = 16;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned SYM_W      = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_USER_W = 2;

  // Bit positions inside in_tdata
  localparam int unsigned IDX_LSB  = 0;
  localparam int unsigned CODE_LSB = IDX_LSB + IDXF_W;
  localparam int unsigned LEN_LSB  = CODE_LSB + CODE_W;
  localparam int unsigned SYM_LSB  = LEN_LSB + LEN_W;
  localparam int unsigned BYTE_LSB = SYM_LSB + SYM_W;

  // Item kinds carried in in_tuser
  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_DATA    = 2'd1,
    OP_RESTART = 2'd2
  } pcsd_op_t;

  // Stream parsing phase
  typedef enum logic [1:0] {
    PH_HEADER,
    PH_DECODE,
    PH_DONE,
    PH_HALT
  } pcsd_phase_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIT,
    ST_SCAN,
    ST_EMIT,
    ST_FLUSH
  } pcsd_state_t;

  // Controller to datapath
  typedef struct packed {
    logic tbl_write;
    logic restart;
    logic load_byte;
    logic bit_step;
    logic bit_next;
    logic scan_next;
    logic scan_hit;
    logic scan_err;
    logic emit;
    logic flush;
  } pcsd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic decode_bit;
    logic last_bit;
    logic hit;
    logic scan_end;
    logic scan_err;
    logic pend_valid;
    logic out_free;
  } pcsd_status_t;

endpackage

/* hdl/pcsd_table.sv */
// Code table memory: one write port, one registered read port.
module pcsd_table import pcsd_pkg::*; #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDX_W = 6,
  parameter int unsigned SW    = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [IDX_W-1:0]  waddr,
  input  logic [CODE_W-1:0] wcode,
  input  logic [LEN_W-1:0]  wlen,
  input  logic [SW-1:0]     wsym,
  input  logic [IDX_W-1:0]  raddr,
  output logic [CODE_W-1:0] rcode,
  output logic [LEN_W-1:0]  rlen,
  output logic [SW-1:0]     rsym
);

  logic [CODE_W-1:0] code_mem [DEPTH];
  logic [LEN_W-1:0]  len_mem  [DEPTH];
  logic [SW-1:0]     sym_mem  [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      code_mem[waddr] <= wcode;
      len_mem[waddr]  <= wlen;
      sym_mem[waddr]  <= wsym;
    end
  end

  // read port, data registered from the address
  always_ff @(posedge clk) begin
    rcode <= code_mem[raddr];
    rlen  <= len_mem[raddr];
    rsym  <= sym_mem[raddr];
  end

endmodule

/* hdl/pcsd_ctrl.sv */
// Sequencing state machine: bit steps, table scan, result hand-off.
module pcsd_ctrl import pcsd_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic [OP_W-1:0] in_op,
  output logic            in_tready,
  input  pcsd_status_t    st,
  output pcsd_cmd_t       cmd
);

  pcsd_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          priority if (in_op == OP_LOAD) begin
            cmd.tbl_write = 1'b1;
          end else if (in_op == OP_RESTART) begin
            cmd.restart = 1'b1;
          end else if (in_op == OP_DATA) begin
            cmd.load_byte = 1'b1;
            state_nxt     = ST_BIT;
          end else begin
            // unused kind, dropped
          end
        end
      end
      ST_BIT: begin
        cmd.bit_step = 1'b1;
        if (st.decode_bit) begin
          state_nxt = ST_SCAN;
        end else if (st.last_bit) begin
          state_nxt = ST_FLUSH;
        end else begin
          cmd.bit_next = 1'b1;
        end
      end
      ST_SCAN: begin
        priority if (st.hit) begin
          cmd.scan_hit = 1'b1;
          state_nxt    = ST_EMIT;
        end else if (st.scan_err) begin
          cmd.scan_err = 1'b1;
          state_nxt    = ST_EMIT;
        end else if (st.scan_end) begin
          if (st.last_bit) begin
            state_nxt = ST_FLUSH;
          end else begin
            cmd.bit_next = 1'b1;
            state_nxt    = ST_BIT;
          end
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      ST_EMIT: begin
        if (!st.pend_valid || st.out_free) begin
          cmd.emit = 1'b1;
          if (st.last_bit) begin
            state_nxt = ST_FLUSH;
          end else begin
            cmd.bit_next = 1'b1;
            state_nxt    = ST_BIT;
          end
        end
      end
      ST_FLUSH: begin
        if (!st.pend_valid) begin
          state_nxt = ST_IDLE;
        end else if (st.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/pcsd_datapath.sv */
// Decoder datapath: bit shifter, header count, code accumulator, scan
// compare, pending result and output register.
module pcsd_datapath import pcsd_pkg::*; #(
  parameter int unsigned MAX_ENTRIES   = 64,
  parameter int unsigned MAX_CODE_BITS = 16,
  parameter int unsigned HEADER_BITS   = 16,
  parameter int unsigned IDX_W         = 6,
  parameter int unsigned SW            = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pcsd_cmd_t         cmd,
  output pcsd_status_t      st,
  // configuration
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_wr_data,
  // input item fields
  input  logic [IDXF_W-1:0] in_entry_index,
  input  logic [CODE_W-1:0] in_entry_code,
  input  logic [LEN_W-1:0]  in_entry_length,
  input  logic [SYM_W-1:0]  in_entry_symbol,
  input  logic [BYTE_W-1:0] in_data_byte,
  // code table
  output logic              tbl_we,
  output logic [IDX_W-1:0]  tbl_waddr,
  output logic [CODE_W-1:0] tbl_wcode,
  output logic [LEN_W-1:0]  tbl_wlen,
  output logic [SW-1:0]     tbl_wsym,
  output logic [IDX_W-1:0]  tbl_raddr,
  input  logic [CODE_W-1:0] tbl_rcode,
  input  logic [LEN_W-1:0]  tbl_rlen,
  input  logic [SW-1:0]     tbl_rsym,
  // result
  input  logic              out_ready,
  output logic              out_valid,
  output logic [SYM_W-1:0]  out_symbol,
  output logic              out_status,
  output logic              out_last_of_stream,
  output logic              out_last_of_item
);

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned AB_W  = $clog2(MAX_CODE_BITS + 1);
  localparam int unsigned HS_W  = $clog2(HEADER_BITS + 1);
  localparam int unsigned BIT_W = $clog2(BYTE_W);

  logic [CFG_W-1:0]         entries_r;
  logic [BYTE_W-1:0]        byte_r;
  logic [BIT_W-1:0]         bit_idx_r;
  pcsd_phase_t              phase_r, phase_nxt;
  logic [MAX_CODE_BITS-1:0] acc_r, acc_nxt, acc_shift;
  logic [AB_W-1:0]          acc_bits_r, acc_bits_nxt;
  logic [HS_W-1:0]          hdr_seen_r, hdr_seen_nxt, hdr_seen_inc;
  logic [HEADER_BITS-1:0]   remain_r, remain_nxt, remain_shift, remain_dec;
  logic [CNT_W-1:0]         scan_idx_r, scan_idx_nxt, n_eff;
  logic                     cur_bit;
  logic [31:0]              len_mask;
  logic                     hit, scan_end, acc_full;

  logic [SW-1:0]            res_sym_r;
  logic                     res_err_r, res_los_r;
  logic                     pend_valid_r;
  logic [SW-1:0]            pend_sym_r;
  logic                     pend_err_r, pend_los_r;
  logic                     out_valid_r;
  logic [SW-1:0]            out_sym_r;
  logic                     out_err_r, out_los_r, out_loi_r;
  logic                     out_free, move;

  // entry count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= CFG_W'(1);
    end else if (cfg_wr_en) begin
      entries_r <= cfg_wr_data;
    end
  end

  assign n_eff = (32'(entries_r) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES) : CNT_W'(entries_r);

  // table loads; slots past the table depth are dropped
  assign tbl_we    = cmd.tbl_write && (32'(in_entry_index) < MAX_ENTRIES);
  assign tbl_waddr = IDX_W'(in_entry_index);
  assign tbl_wcode = in_entry_code;
  assign tbl_wlen  = in_entry_length;
  assign tbl_wsym  = SW'(in_entry_symbol);

  // byte shifter, MSB first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_idx_r <= '0;
    end else if (cmd.load_byte) begin
      bit_idx_r <= BIT_W'(BYTE_W - 1);
    end else if (cmd.bit_next) begin
      bit_idx_r <= bit_idx_r - BIT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      byte_r <= in_data_byte;
    end
  end

  assign cur_bit = byte_r[bit_idx_r];

  assign acc_shift    = {acc_r[MAX_CODE_BITS-2:0], cur_bit};
  assign remain_shift = {remain_r[HEADER_BITS-2:0], cur_bit};
  assign remain_dec   = remain_r - HEADER_BITS'(1);
  assign hdr_seen_inc = hdr_seen_r + HS_W'(1);

  // parse state update
  always_comb begin
    phase_nxt    = phase_r;
    acc_nxt      = acc_r;
    acc_bits_nxt = acc_bits_r;
    hdr_seen_nxt = hdr_seen_r;
    remain_nxt   = remain_r;
    priority if (cmd.restart) begin
      phase_nxt    = PH_HEADER;
      acc_nxt      = '0;
      acc_bits_nxt = '0;
      hdr_seen_nxt = '0;
      remain_nxt   = '0;
    end else if (cmd.bit_step) begin
      unique case (phase_r)
        PH_HEADER: begin
          remain_nxt   = remain_shift;
          hdr_seen_nxt = hdr_seen_inc;
          if (32'(hdr_seen_inc) >= HEADER_BITS) begin
            phase_nxt = (remain_shift == '0) ? PH_DONE : PH_DECODE;
          end
        end
        PH_DECODE: begin
          acc_nxt      = acc_shift;
          acc_bits_nxt = acc_bits_r + AB_W'(1);
        end
        default: begin
          // done or halted: bit ignored
        end
      endcase
    end else if (cmd.scan_hit) begin
      acc_nxt      = '0;
      acc_bits_nxt = '0;
      remain_nxt   = remain_dec;
      if (remain_dec == '0) begin
        phase_nxt = PH_DONE;
      end
    end else if (cmd.scan_err) begin
      acc_nxt      = '0;
      acc_bits_nxt = '0;
      phase_nxt    = PH_HALT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      acc_r      <= '0;
      acc_bits_r <= '0;
      hdr_seen_r <= '0;
      remain_r   <= '0;
    end else begin
      phase_r    <= phase_nxt;
      acc_r      <= acc_nxt;
      acc_bits_r <= acc_bits_nxt;
      hdr_seen_r <= hdr_seen_nxt;
      remain_r   <= remain_nxt;
    end
  end

  // scan pointer; the table read follows its next value
  always_comb begin
    priority if (cmd.bit_step) begin
      scan_idx_nxt = '0;
    end else if (cmd.scan_next) begin
      scan_idx_nxt = scan_idx_r + CNT_W'(1);
    end else begin
      scan_idx_nxt = scan_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
    end else begin
      scan_idx_r <= scan_idx_nxt;
    end
  end

  assign tbl_raddr = scan_idx_nxt[IDX_W-1:0];

  // compare the entry read for scan_idx_r
  assign len_mask = (32'd1 << tbl_rlen) - 32'd1;
  assign hit      = (32'(scan_idx_r) < 32'(n_eff))
                 && (32'(tbl_rlen) == 32'(acc_bits_r))
                 && ((32'(tbl_rcode) & len_mask) == 32'(acc_r));
  assign scan_end = (32'(scan_idx_r) + 32'd1) >= 32'(n_eff);
  assign acc_full = 32'(acc_bits_r) >= MAX_CODE_BITS;

  // new result
  always_ff @(posedge clk) begin
    if (cmd.scan_hit) begin
      res_sym_r <= tbl_rsym;
      res_err_r <= 1'b0;
      res_los_r <= (remain_dec == '0);
    end else if (cmd.scan_err) begin
      res_sym_r <= '0;
      res_err_r <= 1'b1;
      res_los_r <= 1'b0;
    end
  end

  // pending result waits until it is known whether it ends the byte
  assign out_free = !out_valid_r || out_ready;
  assign move     = (cmd.emit || cmd.flush) && pend_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      pend_valid_r <= 1'b1;
    end else if (cmd.flush) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pend_sym_r <= res_sym_r;
      pend_err_r <= res_err_r;
      pend_los_r <= res_los_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_sym_r <= pend_sym_r;
      out_err_r <= pend_err_r;
      out_los_r <= pend_los_r;
      out_loi_r <= cmd.flush;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_symbol         = SYM_W'(out_sym_r);
  assign out_status         = out_err_r;
  assign out_last_of_stream = out_los_r;
  assign out_last_of_item   = out_loi_r;

  // status to the controller
  assign st.decode_bit = (phase_r == PH_DECODE);
  assign st.last_bit   = (bit_idx_r == '0);
  assign st.hit        = hit;
  assign st.scan_end   = scan_end;
  assign st.scan_err   = scan_end && !hit && acc_full;
  assign st.pend_valid = pend_valid_r;
  assign st.out_free   = out_free;

endmodule

/* hdl/prefix_code_stream_decoder_top.sv */
// Top level of the table-driven prefix code stream decoder.
//
//  channel | direction | transfer contents
//  --------+-----------+------------------------------------------------------
//  in_     | slave     | tuser opcode; tdata entry fields and data byte
//  out_    | master    | tdata symbol; tuser status, last_of_item; tlast stream end
//  cfg_    | write     | entries_in_use, taken on every cycle with cfg_wr_en
//
// Load, restart and ignored items are handled in the idle state. A data byte is
// accepted there, worked bit by bit and closed by a flush step: in header, done
// or halted phase a bit is a bare bit step; in decode phase a bit step is followed
// by a table scan, entry by entry over the single read port, up to the match or
// over max(min(entries_in_use, MAX_ENTRIES), 1) entries, and an emit per result.
// rst_n is synchronous; the code table is not cleared and holds until reloaded.
// A full output register with a result pending stalls the emit or flush step.
`include "prefix_code_stream_decoder_top_defines.svh"
module prefix_code_stream_decoder_top import pcsd_pkg::*; #(
  parameter int unsigned MAX_ENTRIES   = 64,
  parameter int unsigned MAX_CODE_BITS = 16,
  parameter int unsigned HEADER_BITS   = 16,
  parameter int unsigned SYMBOL_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input transfers
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // entry_index[5:0], entry_code[21:6], entry_length[26:22],
  // entry_symbol[42:27], data_byte[50:43], zero fill [55:51]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // opcode[1:0]
  input  logic [OP_W-1:0]       in_tuser,
  // result transfers
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // symbol[15:0]
  output logic [SYM_W-1:0]      out_tdata,
  // status[0], last_of_item[1]
  output logic [OUT_USER_W-1:0] out_tuser,
  // last_of_stream
  output logic                  out_tlast,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [CFG_W-1:0]      cfg_wr_data
);

  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned SW    = (SYMBOL_BITS < SYM_W) ? SYMBOL_BITS : SYM_W;

  pcsd_cmd_t         cmd;
  pcsd_status_t      st;
  logic              tbl_we;
  logic [IDX_W-1:0]  tbl_waddr, tbl_raddr;
  logic [CODE_W-1:0] tbl_wcode, tbl_rcode;
  logic [LEN_W-1:0]  tbl_wlen, tbl_rlen;
  logic [SW-1:0]     tbl_wsym, tbl_rsym;
  logic              out_status, out_loi;

  // controller
  pcsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  // datapath
  pcsd_datapath #(
    .MAX_ENTRIES   (MAX_ENTRIES),
    .MAX_CODE_BITS (MAX_CODE_BITS),
    .HEADER_BITS   (HEADER_BITS),
    .IDX_W         (IDX_W),
    .SW            (SW)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_entry_index     (in_tdata[IDX_LSB +: IDXF_W]),
    .in_entry_code      (in_tdata[CODE_LSB +: CODE_W]),
    .in_entry_length    (in_tdata[LEN_LSB +: LEN_W]),
    .in_entry_symbol    (in_tdata[SYM_LSB +: SYM_W]),
    .in_data_byte       (in_tdata[BYTE_LSB +: BYTE_W]),
    .tbl_we             (tbl_we),
    .tbl_waddr          (tbl_waddr),
    .tbl_wcode          (tbl_wcode),
    .tbl_wlen           (tbl_wlen),
    .tbl_wsym           (tbl_wsym),
    .tbl_raddr          (tbl_raddr),
    .tbl_rcode          (tbl_rcode),
    .tbl_rlen           (tbl_rlen),
    .tbl_rsym           (tbl_rsym),
    .out_ready          (out_tready),
    .out_valid          (out_tvalid),
    .out_symbol         (out_tdata),
    .out_status         (out_status),
    .out_last_of_stream (out_tlast),
    .out_last_of_item   (out_loi)
  );

  // code table
  pcsd_table #(
    .DEPTH (MAX_ENTRIES),
    .IDX_W (IDX_W),
    .SW    (SW)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wcode (tbl_wcode),
    .wlen  (tbl_wlen),
    .wsym  (tbl_wsym),
    .raddr (tbl_raddr),
    .rcode (tbl_rcode),
    .rlen  (tbl_rlen),
    .rsym  (tbl_rsym)
  );

  assign out_tuser = {out_loi, out_status};

  // a byte is fully handed off before the next item is taken
  `PCSD_ASSERT_IMP(a_no_pend_when_ready, in_tready, !st.pend_valid)
  // an error halts decoding, so it always closes its byte and never ends the stream
  `PCSD_ASSERT_IMP(a_err_closes_byte, out_tvalid && out_tuser[0], out_tuser[1] && !out_tlast)
  // a data byte keeps the input closed while its bits are worked
  `PCSD_ASSERT_NXT(a_busy_after_byte, in_tvalid && in_tready && (in_tuser == OP_DATA), !in_tready)

endmodule
